// ===== hdl/dtfsk_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the dual-tone FSK NCO.
`timescale 1ns / 1ps
package dtfsk_pkg;

   localparam int PHASE_BITS       = 32;
   localparam int TABLE_INDEX_BITS = 10;
   localparam int SAMPLE_BITS      = 16;

   localparam int CSR_BITS         = 32;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int OUT_BITS         = 16;
   localparam int MAG_BITS         = OUT_BITS - 1;
   localparam int QUARTER          = 1 << (TABLE_INDEX_BITS - 2);
   localparam int K_BITS           = TABLE_INDEX_BITS - 1;
   localparam int ROUND_SHIFT      = 31 - SAMPLE_BITS;
   localparam int TAYLOR_TERMS     = 8;

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS   = QUEUE_PTR_BITS + 1;

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   typedef logic [PHASE_BITS-1:0]  phase_type;
   typedef logic [CSR_BITS-1:0]    csr_data_type;
   typedef logic [K_BITS-1:0]      k_type;
   typedef logic [MAG_BITS-1:0]    mag_type;
   typedef logic signed [OUT_BITS-1:0] sample_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LO_PHASE_STEP  = 2'd0,
      CSR_HI_PHASE_STEP  = 2'd1,
      CSR_LO_START_PHASE = 2'd2,
      CSR_HI_START_PHASE = 2'd3
   } csr_index_type;

   // folded table address and sign for one tone
   typedef struct packed {
      logic  neg;
      k_type k;
   } tone_type;

   typedef struct packed {
      tone_type lo;
      tone_type hi;
   } entry_type;

   typedef mag_type qtr_rom_type [QUARTER+1];

   function automatic tone_type fold_phase(phase_type phase);
      logic [TABLE_INDEX_BITS-1:0] idx;
      logic [TABLE_INDEX_BITS-3:0] r;
      logic [1:0]                  quad;
      tone_type                    t;
      idx    = phase[PHASE_BITS-1 -: TABLE_INDEX_BITS];
      r      = idx[TABLE_INDEX_BITS-3:0];
      quad   = idx[TABLE_INDEX_BITS-1 -: 2];
      t.neg  = quad[1];
      t.k    = quad[0] ? (k_type'(QUARTER) - k_type'(r)) : k_type'(r);
      return t;
   endfunction

   // restoring long division, used only while the table is built
   function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem  = rem - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Q30 Taylor series of sin(2*pi*k/N), rounded to the output magnitude
   function automatic mag_type quarter_mag(int unsigned k);
      logic [63:0] theta;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] div;
      logic [63:0] m;
      logic [63:0] cap;
      theta = (TWO_PI_Q30 * 64'(k)) >> TABLE_INDEX_BITS;
      x2    = (theta * theta) >> 30;
      term  = theta;
      sum   = theta;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         div  = 64'((2 * n) * (2 * n + 1));
         term = long_div((term * x2) >> 30, div);
         if ((n & 1) == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      cap = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
      m   = (sum + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      if (m > cap) begin
         m = cap;
      end
      if (SAMPLE_BITS >= OUT_BITS) begin
         m = m >> (SAMPLE_BITS - OUT_BITS);
      end else begin
         m = m << (OUT_BITS - SAMPLE_BITS);
      end
      return mag_type'(m);
   endfunction

   function automatic qtr_rom_type build_qtr_rom();
      qtr_rom_type t;
      for (int k = 0; k <= QUARTER; k++) begin
         t[k] = quarter_mag(k);
      end
      return t;
   endfunction

   localparam qtr_rom_type QTR_ROM = build_qtr_rom();

endpackage

// ===== hdl/dtfsk_front.sv =====
// Front end: configuration registers, phase accumulators and quadrant folding.
`timescale 1ns / 1ps
module dtfsk_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dtfsk_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  dtfsk_pkg::csr_data_type             csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                q_push,
   output dtfsk_pkg::entry_type                q_data,
   input  logic                                q_ready
);

   dtfsk_pkg::csr_data_type lo_step_ff,  lo_step_in;
   dtfsk_pkg::csr_data_type hi_step_ff,  hi_step_in;
   dtfsk_pkg::csr_data_type lo_start_ff, lo_start_in;
   dtfsk_pkg::csr_data_type hi_start_ff, hi_start_in;
   dtfsk_pkg::phase_type    lo_phase_ff, lo_phase_in;
   dtfsk_pkg::phase_type    hi_phase_ff, hi_phase_in;
   dtfsk_pkg::phase_type    lo_next;
   dtfsk_pkg::phase_type    hi_next;
   logic                    accept;

   always_comb begin
      lo_step_in  = lo_step_ff;
      hi_step_in  = hi_step_ff;
      lo_start_in = lo_start_ff;
      hi_start_in = hi_start_ff;
      if (csr_write_enable) begin
         unique case (dtfsk_pkg::csr_index_type'(csr_index))
            dtfsk_pkg::CSR_LO_PHASE_STEP:  lo_step_in  = csr_write_data;
            dtfsk_pkg::CSR_HI_PHASE_STEP:  hi_step_in  = csr_write_data;
            dtfsk_pkg::CSR_LO_START_PHASE: lo_start_in = csr_write_data;
            dtfsk_pkg::CSR_HI_START_PHASE: hi_start_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      accept    = req_valid && q_ready;
      req_ready = q_ready;
      lo_next   = (req_restart ? dtfsk_pkg::phase_type'(lo_start_ff) : lo_phase_ff)
                  + dtfsk_pkg::phase_type'(lo_step_ff);
      hi_next   = (req_restart ? dtfsk_pkg::phase_type'(hi_start_ff) : hi_phase_ff)
                  + dtfsk_pkg::phase_type'(hi_step_ff);
      lo_phase_in = accept ? lo_next : lo_phase_ff;
      hi_phase_in = accept ? hi_next : hi_phase_ff;
      q_push    = accept;
      q_data.lo = dtfsk_pkg::fold_phase(lo_next);
      q_data.hi = dtfsk_pkg::fold_phase(hi_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_step_ff  <= '0;
         hi_step_ff  <= '0;
         lo_start_ff <= '0;
         hi_start_ff <= '0;
         lo_phase_ff <= '0;
         hi_phase_ff <= '0;
      end else begin
         lo_step_ff  <= lo_step_in;
         hi_step_ff  <= hi_step_in;
         lo_start_ff <= lo_start_in;
         hi_start_ff <= hi_start_in;
         lo_phase_ff <= lo_phase_in;
         hi_phase_ff <= hi_phase_in;
      end
   end

endmodule

// ===== hdl/dtfsk_queue.sv =====
// Small FIFO of folded table addresses between front and back end.
`timescale 1ns / 1ps
module dtfsk_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dtfsk_pkg::entry_type push_data,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output dtfsk_pkg::entry_type pop_data
);

   dtfsk_pkg::entry_type                      slots_ff [dtfsk_pkg::QUEUE_DEPTH];
   logic [dtfsk_pkg::QUEUE_PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [dtfsk_pkg::QUEUE_PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [dtfsk_pkg::QUEUE_CNT_BITS-1:0]      count_ff,  count_in;
   logic                                      do_push;
   logic                                      do_pop;

   always_comb begin
      push_ready = count_ff != dtfsk_pkg::QUEUE_CNT_BITS'(dtfsk_pkg::QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = slots_ff[rd_ptr_ff];
      do_push    = push && push_ready;
      do_pop     = pop && pop_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in   = count_ff + dtfsk_pkg::QUEUE_CNT_BITS'(do_push)
                   - dtfsk_pkg::QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/dtfsk_back.sv =====
// Back end: quarter-wave table lookup, sign restore and output register.
`timescale 1ns / 1ps
module dtfsk_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  dtfsk_pkg::entry_type  q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dtfsk_pkg::sample_type rsp_lo_sample,
   output dtfsk_pkg::sample_type rsp_hi_sample
);

   logic                  rsp_valid_ff, rsp_valid_in;
   dtfsk_pkg::sample_type lo_sample_ff, lo_sample_in;
   dtfsk_pkg::sample_type hi_sample_ff, hi_sample_in;
   dtfsk_pkg::sample_type lo_mag;
   dtfsk_pkg::sample_type hi_mag;
   logic                  load;

   always_comb begin
      load         = q_valid && (!rsp_valid_ff || rsp_ready);
      q_pop        = load;
      lo_mag       = dtfsk_pkg::sample_type'({1'b0, dtfsk_pkg::QTR_ROM[q_data.lo.k]});
      hi_mag       = dtfsk_pkg::sample_type'({1'b0, dtfsk_pkg::QTR_ROM[q_data.hi.k]});
      lo_sample_in = q_data.lo.neg ? -lo_mag : lo_mag;
      hi_sample_in = q_data.hi.neg ? -hi_mag : hi_mag;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_valid     = rsp_valid_ff;
      rsp_lo_sample = lo_sample_ff;
      rsp_hi_sample = hi_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_sample_ff <= lo_sample_in;
         hi_sample_ff <= hi_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/dual_tone_fsk_reference_nco.sv =====
// Top level of the dual-tone FSK reference NCO.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_ready, req_restart       | in
//  rsp     | rsp_valid, rsp_ready, rsp_lo/hi_sample  | out
//  csr     | csr_write_enable, csr_index, csr_write_data | in
//
// One tick per clock while req_ready is high; a tick is written into the queue at the req
// transfer, then looked up in the table into the output register, which raises rsp_valid.
// Synchronous reset zeroes phases, step and start registers, queue and output valid.
// A four-entry queue decouples the sides; req_ready falls only when it is full.
`timescale 1ns / 1ps
module dual_tone_fsk_reference_nco (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dtfsk_pkg::OUT_BITS-1:0] rsp_lo_sample,
   output logic signed [dtfsk_pkg::OUT_BITS-1:0] rsp_hi_sample,
   input  logic                                 csr_write_enable,
   input  logic [dtfsk_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dtfsk_pkg::CSR_BITS-1:0]       csr_write_data
);

   logic                 q_push;
   logic                 q_ready;
   logic                 q_pop;
   logic                 q_valid;
   dtfsk_pkg::entry_type q_wr_data;
   dtfsk_pkg::entry_type q_rd_data;

   dtfsk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .q_push           (q_push),
      .q_data           (q_wr_data),
      .q_ready          (q_ready)
   );

   dtfsk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_wr_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_rd_data)
   );

   dtfsk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_rd_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_lo_sample (rsp_lo_sample),
      .rsp_hi_sample (rsp_hi_sample)
   );

endmodule

// ===== bench/tb_dual_tone_fsk_reference_nco.sv =====
// Self-checking testbench for the dual-tone FSK reference NCO with a sine predictor.
`timescale 1ns / 1ps
module tb_dual_tone_fsk_reference_nco;
   import dtfsk_pkg::*;

   localparam logic [63:0] FULL_TURN_Q30 = 64'd6746518852;
   localparam sample_type  FULL_POS      = 16'sd32767;
   localparam sample_type  FULL_NEG      = -16'sd32767;
   localparam int          STALL_LIMIT   = 5000;
   localparam int          SEGMENTS      = 9;
   localparam int          SEG_TICKS     = 48;

   typedef struct packed {
      sample_type lo;
      sample_type hi;
   } tone_pair_t;

   typedef struct packed {
      logic         load_regs;
      csr_data_type lo_step;
      csr_data_type hi_step;
      csr_data_type lo_start;
      csr_data_type hi_start;
      logic         restart;
      logic         typed;
      sample_type   lo_val;
      sample_type   hi_val;
   } tick_row_t;

   localparam int DIRECTED_ROWS = 21;
   localparam tick_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 16'sd0, 16'sd0},
      '{1'b1, 32'h4000_0000, 32'hC000_0000, 32'h0, 32'h0, 1'b1, 1'b1, FULL_POS, FULL_NEG},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, FULL_NEG, FULL_POS},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 16'sd0, 16'sd0},
      '{1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, 32'h0, 32'h0, 32'h4000_0000, 32'hBFFF_FFFF, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, 32'h0040_0000, 32'h00C0_0000, 32'h3FC0_0000, 32'h7FC0_0000, 1'b1, 1'b0,
        16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
        16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b1, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b1, 1'b0,
        16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 16'sd0, 16'sd0},
      '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 16'sd0, 16'sd0}
   };

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic                 req_restart      = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   sample_type           rsp_lo_sample;
   sample_type           rsp_hi_sample;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   csr_data_type         csr_write_data   = '0;

   phase_type  lo_incr   = '0;
   phase_type  hi_incr   = '0;
   phase_type  lo_origin = '0;
   phase_type  hi_origin = '0;
   phase_type  lo_acc    = '0;
   phase_type  hi_acc    = '0;
   tone_pair_t pending_pairs [$];
   int         mismatches   = 0;
   int         idle_cycles  = 0;
   bit         steady_flow  = 1'b0;

   dual_tone_fsk_reference_nco dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lo_sample    (rsp_lo_sample),
      .rsp_hi_sample    (rsp_hi_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // first-quadrant magnitude, Q30 Taylor series rounded to Q15
   function automatic logic [15:0] sine_magnitude(int unsigned k);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] tm;
      logic [63:0] acc;
      logic [63:0] rounded;
      int          rshift;
      ang    = (FULL_TURN_Q30 * 64'(k)) >> TABLE_INDEX_BITS;
      ang_sq = (ang * ang) >> 30;
      tm     = ang;
      acc    = ang;
      rshift = 31 - SAMPLE_BITS;
      for (int i = 1; i <= 8; i++) begin
         tm = ((tm * ang_sq) >> 30) / 64'((2 * i) * (2 * i + 1));
         if (i % 2 == 1) begin
            acc = (acc >= tm) ? acc - tm : 64'd0;
         end else begin
            acc = acc + tm;
         end
      end
      rounded = (acc + (64'd1 << (rshift - 1))) >> rshift;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[15:0];
   endfunction

   function automatic sample_type tone_sample(phase_type ph);
      logic [TABLE_INDEX_BITS-1:0] idx;
      logic [1:0]                  quad;
      int unsigned                 r;
      int unsigned                 k;
      logic [15:0]                 mag;
      idx  = ph[PHASE_BITS-1 -: TABLE_INDEX_BITS];
      quad = idx[TABLE_INDEX_BITS-1 -: 2];
      r    = int'(idx[TABLE_INDEX_BITS-3:0]);
      k    = quad[0] ? (QUARTER - r) : r;
      mag  = sine_magnitude(k);
      return quad[1] ? sample_type'(16'd0 - mag) : sample_type'(mag);
   endfunction

   task automatic advance_tones(input logic rs, output tone_pair_t p);
      if (rs) begin
         lo_acc = lo_origin;
         hi_acc = hi_origin;
      end
      lo_acc = lo_acc + lo_incr;
      hi_acc = hi_acc + hi_incr;
      p.lo   = tone_sample(lo_acc);
      p.hi   = tone_sample(hi_acc);
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic csr_data_type pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end else if (r < 4) begin
         return csr_data_type'($urandom_range(0, 1 << 20));
      end
      return csr_data_type'($urandom);
   endfunction

   task automatic send_tick(input logic rs, input logic typed, input tone_pair_t given);
      tone_pair_t p;
      int         gap;
      req_valid   <= 1'b1;
      req_restart <= rs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_tones(rs, p);
      pending_pairs.push_back(typed ? given : p);
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every sample pair is back, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input csr_data_type val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_LO_PHASE_STEP:  lo_incr   = val;
         CSR_HI_PHASE_STEP:  hi_incr   = val;
         CSR_LO_START_PHASE: lo_origin = val;
         CSR_HI_START_PHASE: hi_origin = val;
         default: ;
      endcase
   endtask

   task automatic program_tones(input csr_data_type lo_s, input csr_data_type hi_s,
                                input csr_data_type lo_o, input csr_data_type hi_o);
      put_csr(CSR_LO_PHASE_STEP, lo_s);
      put_csr(CSR_HI_PHASE_STEP, hi_s);
      put_csr(CSR_LO_START_PHASE, lo_o);
      put_csr(CSR_HI_START_PHASE, hi_o);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int n;
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      tone_pair_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transfer, expected none, actual lo %0d hi %0d",
                     $time, rsp_lo_sample, rsp_hi_sample);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_lo_sample !== want.lo) begin
               mismatches++;
               $display("%0t: lo_sample expected %0d actual %0d",
                        $time, want.lo, rsp_lo_sample);
            end
            if (rsp_hi_sample !== want.hi) begin
               mismatches++;
               $display("%0t: hi_sample expected %0d actual %0d",
                        $time, want.hi, rsp_hi_sample);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      tone_pair_t given;
      logic       rs;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].load_regs) begin
            settle();
            program_tones(DIRECTED[r].lo_step, DIRECTED[r].hi_step,
                          DIRECTED[r].lo_start, DIRECTED[r].hi_start);
         end
         given.lo = DIRECTED[r].lo_val;
         given.hi = DIRECTED[r].hi_val;
         send_tick(DIRECTED[r].restart, DIRECTED[r].typed, given);
      end

      given = '0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         steady_flow = (seg == 4);
         if (seg == 0) begin
            program_tones('0, '1, '1, '0);
         end else if (seg == 1) begin
            program_tones('1, '0, '0, '1);
         end else begin
            program_tones(pick_word(), pick_word(), pick_word(), pick_word());
         end
         for (int i = 0; i < SEG_TICKS; i++) begin
            rs = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) == 0);
            send_tick(rs, 1'b0, given);
         end
      end
      steady_flow = 1'b0;

      settle();
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== dual_tone_fsk_reference_nco.f =====
hdl/dtfsk_pkg.sv
hdl/dtfsk_front.sv
hdl/dtfsk_queue.sv
hdl/dtfsk_back.sv
hdl/dual_tone_fsk_reference_nco.sv
bench/tb_dual_tone_fsk_reference_nco.sv
